// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the binner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CHB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CHB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/chb_pkg.sv =====
// Package: widths, register indexes, reset values and sequencer states of the binner.
`default_nettype none

package chb_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int STEP_W     = 23;
    localparam int BINS_W     = 5;
    localparam int INDEX_W    = 4;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] MIN_VALUE_RST   = 24'hFFCE00;
    localparam logic [STEP_W-1:0]   BIN_STEP_RST    = 23'd6400;
    localparam logic [BINS_W-1:0]   BINS_IN_USE_RST = 5'd10;

    localparam logic [COUNT_W-1:0]  COUNT_FULL = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_UPD
    } chb_state_t;

endpackage

`default_nettype wire

// ===== rtl/clamped_histogram_binner_unit.sv =====
// Top level: clamped fixed-width histogram binner with a counter memory.
// Use:
//   Input channel (in_valid/in_ready, sample) takes one signed Q15.8 sample per
//   request. Output channel (out_valid/out_ready, bin_index, bin_count) returns
//   the clamped bin and that bin's saturated count after the increment.
//   Configuration (cfg_write, cfg_index, cfg_data) writes min_value, bin_step or
//   bins_in_use, one register per write; write only while the block is idle.
// Operation:
//   The bin is found by a restoring divider that resolves one quotient bit per
//   cycle, after a top step that only tests for overflow and ends the division
//   early when it finds one. A sample below min_value skips the divider. The
//   counter then takes a read step and a modify/write step on the memory. A new
//   request is taken only once the previous one has written its counter.
// Reset:
//   Configuration returns to its defaults and a clearing pass zeroes the counter
//   memory, one entry per cycle; in_ready stays low until the pass is done.
// Stall:
//   A result waits in the output register; the next request is already taken
//   and worked on, and its counter write waits until the register is free.
`default_nettype none

module clamped_histogram_binner_unit #(
    parameter int MAX_BINS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [chb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [chb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [chb_pkg::SAMPLE_W-1:0] sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [chb_pkg::INDEX_W-1:0]            bin_index,
    output logic [chb_pkg::COUNT_W-1:0]            bin_count
);

    import chb_pkg::*;

    `include "assert_macros.svh"

    localparam int IW   = $clog2(MAX_BINS);
    localparam int CNTW = $clog2(IW + 1);
    localparam int CW   = STEP_W + IW + 2;
    localparam logic [CNTW-1:0] CNT_TOP = CNTW'(IW);
    localparam logic [IW-1:0]   CLR_LAST = IW'(MAX_BINS - 1);

    // Configuration registers
    logic [SAMPLE_W-1:0] min_value_reg;
    logic [STEP_W-1:0]   bin_step_reg;
    logic [BINS_W-1:0]   bins_in_use_reg;

    // Control
    chb_state_t          state_reg, state_next;
    logic [IW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath
    logic [CW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       dvs_reg, dvs_next;
    logic [IW-1:0]       q_reg, q_next;
    logic                ovf_reg, ovf_next;
    logic [IW-1:0]       top_reg, top_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [INDEX_W-1:0]  bin_index_reg, bin_index_next;
    logic [COUNT_W-1:0]  bin_count_reg, bin_count_next;

    // Counter memory
    logic [COUNT_W-1:0]  mem [MAX_BINS];
    logic [COUNT_W-1:0]  rdata_reg;
    logic                mem_we;
    logic                mem_re;
    logic [IW-1:0]       mem_waddr;
    logic [COUNT_W-1:0]  mem_wdata;

    // Shared combinational terms
    logic                in_acc;
    logic                slot_free;
    logic signed [SAMPLE_W:0] diff;
    logic                diff_neg;
    logic [CW-1:0]       step_eff;
    logic [IW:0]         active;
    logic [IW-1:0]       top_now;
    logic                ge;
    logic [CW-1:0]       rem_sub;
    logic [IW-1:0]       idx_clamp;
    logic [COUNT_W-1:0]  count_inc;

    assign in_acc    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Offset from the lower edge, exact in one extra bit
    assign diff     = {sample[SAMPLE_W-1], sample}
                    - {min_value_reg[SAMPLE_W-1], min_value_reg};
    assign diff_neg = diff[SAMPLE_W];
    assign step_eff = (bin_step_reg == '0) ? CW'(1) : CW'(bin_step_reg);

    // Active bin count clamped to 1..MAX_BINS
    always_comb
    begin
        if (bins_in_use_reg == '0)
            active = (IW + 1)'(1);
        else if (32'(bins_in_use_reg) > MAX_BINS)
            active = (IW + 1)'(MAX_BINS);
        else
            active = (IW + 1)'(bins_in_use_reg);
        top_now = IW'(active - (IW + 1)'(1));
    end

    // One restoring division step
    assign ge      = (rem_reg >= dvs_reg);
    assign rem_sub = rem_reg - dvs_reg;

    // Clamp the quotient to the last active bin
    assign idx_clamp = (ovf_reg || (q_reg > top_reg)) ? top_reg : q_reg;

    // Saturating increment of the stored count
    assign count_inc = (rdata_reg == COUNT_FULL) ? rdata_reg : rdata_reg + COUNT_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == CLR_LAST)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                    state_next = diff_neg ? ST_RD : ST_DIV;
            ST_DIV:
                if ((cnt_reg == '0) || ((cnt_reg == CNT_TOP) && ge))
                    state_next = ST_RD;
            ST_RD:
                state_next = ST_UPD;
            ST_UPD:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = count_inc;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
                in_ready = 1'b1;
            ST_DIV:
                mem_we = 1'b0;
            ST_RD:
                mem_re = 1'b1;
            ST_UPD:
                mem_we = slot_free;
            default:
                in_ready = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        q_next         = q_reg;
        ovf_next       = ovf_reg;
        top_next       = top_reg;
        idx_next       = idx_reg;
        bin_index_next = bin_index_reg;
        bin_count_next = bin_count_reg;

        // drop the result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
                clr_cnt_next = clr_cnt_reg + IW'(1);
            ST_IDLE:
            begin
                // load the divider with the offset and the scaled step
                if (in_acc)
                begin
                    rem_next = CW'(diff[SAMPLE_W-1:0]);
                    dvs_next = step_eff << IW;
                    q_next   = '0;
                    ovf_next = 1'b0;
                    cnt_next = CNT_TOP;
                    top_next = top_now;
                end
            end
            ST_DIV:
            begin
                // top step only tests for a quotient beyond the index range
                if (ge)
                    rem_next = rem_sub;
                if ((cnt_reg == CNT_TOP) && ge)
                    ovf_next = 1'b1;
                q_next   = IW'({q_reg, ge && (cnt_reg != CNT_TOP)});
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - CNTW'(1);
            end
            ST_RD:
                idx_next = idx_clamp;
            ST_UPD:
            begin
                // hand the updated count to the output register
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    bin_index_next = INDEX_W'(idx_reg);
                    bin_count_next = count_inc;
                end
            end
            default:
                cnt_next = cnt_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            min_value_reg   <= MIN_VALUE_RST;
            bin_step_reg    <= BIN_STEP_RST;
            bins_in_use_reg <= BINS_IN_USE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            // configuration write decode
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MIN_VALUE:   min_value_reg   <= cfg_data[SAMPLE_W-1:0];
                    REG_BIN_STEP:    bin_step_reg    <= cfg_data[STEP_W-1:0];
                    REG_BINS_IN_USE: bins_in_use_reg <= cfg_data[BINS_W-1:0];
                    default:         bin_step_reg    <= bin_step_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        q_reg         <= q_next;
        ovf_reg       <= ovf_next;
        top_reg       <= top_next;
        idx_reg       <= idx_next;
        bin_index_reg <= bin_index_next;
        bin_count_reg <= bin_count_next;
    end

    // Counter memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[idx_clamp];
    end

    assign out_valid = out_valid_reg;
    assign bin_index = bin_index_reg;
    assign bin_count = bin_count_reg;

    `CHB_ASSERT_NOW(a_no_accept_in_clear, state_reg == ST_CLEAR, !in_ready,
        "request accepted during the clearing pass")
    `CHB_ASSERT_NOW(a_write_only_clear_or_upd, mem_we,
        (state_reg == ST_CLEAR) || (state_reg == ST_UPD),
        "counter memory written outside clear or update")
    `CHB_ASSERT_NOW(a_idx_in_range, state_reg == ST_UPD, idx_reg <= top_reg,
        "bin index above the last active bin")
    `CHB_ASSERT_NEXT(a_result_loaded, (state_reg == ST_UPD) && slot_free,
        out_valid_reg && (bin_count_reg != '0),
        "update did not load a nonzero count")

endmodule

`default_nettype wire
